/* sv/rmat_pkg.sv */
// ----------------------------------------------------------------------------
// rmat_pkg
// Types and constants shared by the refresh management activation tracker.
// ----------------------------------------------------------------------------
package rmat_pkg;

  localparam int unsigned CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CNT_W-1:0] THRESHOLD_RESET = 16'd80;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_ACT_THRESHOLD = 1'b0;
  localparam logic REG_PER_BANK_MODE = 1'b1;

  typedef struct packed {
    logic       opens_bank;
    logic [1:0] rank;
    logic [5:0] flat_bank;
  } cmd_item_t;

  typedef struct packed {
    logic       all_bank;
    logic [1:0] target_rank;
    logic [5:0] target_bank;
  } rfm_item_t;

  // write-side control of the counter memory
  typedef struct packed {
    logic wr_en;    // write one entry
    logic clr_all;  // invalidate every entry
  } mem_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_RMW
  } state_t;

endpackage

/* sv/rmat_cnt_mem.sv */
// ----------------------------------------------------------------------------
// rmat_cnt_mem
// Per-bank activation counter store: one synchronous RAM with a registered
// read port, plus a valid bit per entry so a bulk clear resets every entry at once.
// ----------------------------------------------------------------------------
module rmat_cnt_mem #(
  parameter int unsigned BANK_COUNT = 64,
  parameter int unsigned BANK_W     = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [BANK_W-1:0]        rd_addr,
  output logic [rmat_pkg::CNT_W-1:0] rd_data,
  input  rmat_pkg::mem_cmd_t       cmd,
  input  logic [BANK_W-1:0]        wr_addr,
  input  logic [rmat_pkg::CNT_W-1:0] wr_data
);

  logic [rmat_pkg::CNT_W-1:0] mem [BANK_COUNT];
  logic [BANK_COUNT-1:0]      valid;
  logic [rmat_pkg::CNT_W-1:0] rd_raw;
  logic                       rd_hit;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_hit <= valid[rd_addr];
      end
      if (cmd.clr_all) begin
        valid <= '0;
      end else if (cmd.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  // an entry never written since the last clear reads as zero
  assign rd_data = rd_hit ? rd_raw : '0;

endmodule

/* sv/refresh_management_act_tracker.sv */
// ----------------------------------------------------------------------------
// refresh_management_act_tracker
// Counts activates per bank and issues a refresh management command when a
// bank's count reaches the programmed threshold.
// The accepting edge registers the counter RAM read; the write-back state then
// writes the counter back and registers the result strobe, one command at a time.
// busy is high during the write-back cycle.
// Reset clears all counters at once through the per-entry valid bits,
// threshold returns to 80, per-bank mode to off. The receiver cannot stall.
// ----------------------------------------------------------------------------
module refresh_management_act_tracker #(
  parameter int unsigned BANK_COUNT = 64,
  parameter int unsigned NUM_RANKS  = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  rmat_pkg::cmd_item_t           item,
  output logic                          result_valid,
  output rmat_pkg::rfm_item_t           result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rmat_pkg::PADDR_W-1:0]  paddr,
  input  logic [rmat_pkg::PDATA_W-1:0]  pwdata,
  output logic [rmat_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned BANK_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

  // configuration
  logic [rmat_pkg::CNT_W-1:0] act_threshold;
  logic                       per_bank_mode;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      act_threshold <= rmat_pkg::THRESHOLD_RESET;
      per_bank_mode <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        rmat_pkg::REG_ACT_THRESHOLD: act_threshold <= pwdata[rmat_pkg::CNT_W-1:0];
        rmat_pkg::REG_PER_BANK_MODE: per_bank_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rmat_pkg::REG_ACT_THRESHOLD: prdata = {{(rmat_pkg::PDATA_W-rmat_pkg::CNT_W){1'b0}},
                                             act_threshold};
      rmat_pkg::REG_PER_BANK_MODE: prdata = {{(rmat_pkg::PDATA_W-1){1'b0}}, per_bank_mode};
      default:                     prdata = '0;
    endcase
  end

  // input beat decode
  rmat_pkg::state_t state, state_next;
  logic             accept;
  logic             in_range;
  logic [BANK_W+5:0] bank_ext;
  logic [BANK_W-1:0] bank_idx;

  assign accept   = start & ~busy;
  assign bank_ext = {{BANK_W{1'b0}}, item.flat_bank};
  assign bank_idx = bank_ext[BANK_W-1:0];
  assign in_range = ({26'd0, item.flat_bank} < 32'(BANK_COUNT)) &&
                    ({30'd0, item.rank} < 32'(NUM_RANKS));

  // held item for the write-back cycle
  logic              act_ok;
  logic [1:0]        hold_rank;
  logic [5:0]        hold_bank;
  logic [BANK_W-1:0] hold_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      act_ok <= 1'b0;
    end else if (accept) begin
      act_ok <= item.opens_bank & in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_rank <= item.rank;
      hold_bank <= item.flat_bank;
      hold_idx  <= bank_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmat_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    unique case (state)
      rmat_pkg::S_IDLE: state_next = accept ? rmat_pkg::S_RMW : rmat_pkg::S_IDLE;
      rmat_pkg::S_RMW:  state_next = rmat_pkg::S_IDLE;
      default:          state_next = rmat_pkg::S_IDLE;
    endcase
  end

  logic in_rmw;

  always_comb begin
    unique case (state)
      rmat_pkg::S_IDLE: begin
        busy   = 1'b0;
        in_rmw = 1'b0;
      end
      rmat_pkg::S_RMW: begin
        busy   = 1'b1;
        in_rmw = 1'b1;
      end
      default: begin
        busy   = 1'b1;
        in_rmw = 1'b0;
      end
    endcase
  end

  // read-modify-write of the bank counter
  logic [rmat_pkg::CNT_W-1:0] cnt_cur;
  logic [rmat_pkg::CNT_W-1:0] cnt_inc;
  logic                       trigger;
  logic                       do_act;
  rmat_pkg::mem_cmd_t         mem_cmd;
  logic [rmat_pkg::CNT_W-1:0] wr_data;

  assign do_act  = in_rmw & act_ok;
  assign cnt_inc = (cnt_cur == rmat_pkg::CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
  assign trigger = cnt_inc >= act_threshold;

  always_comb begin
    mem_cmd.wr_en   = 1'b0;
    mem_cmd.clr_all = 1'b0;
    wr_data         = cnt_inc;
    if (do_act) begin
      if (!trigger) begin
        mem_cmd.wr_en = 1'b1;
      end else if (per_bank_mode) begin
        mem_cmd.wr_en = 1'b1;
        wr_data       = '0;
      end else begin
        mem_cmd.clr_all = 1'b1;
      end
    end
  end

  rmat_cnt_mem #(
    .BANK_COUNT (BANK_COUNT),
    .BANK_W     (BANK_W)
  ) u_cnt_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (bank_idx),
    .rd_data (cnt_cur),
    .cmd     (mem_cmd),
    .wr_addr (hold_idx),
    .wr_data (wr_data)
  );

  // result beat, one cycle wide
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= do_act & trigger;
    end
  end

  always_ff @(posedge clk) begin
    if (do_act & trigger) begin
      result.all_bank    <= ~per_bank_mode;
      result.target_rank <= hold_rank;
      result.target_bank <= hold_bank;
    end
  end

endmodule

/* tb/act_tracker_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// act_tracker_checker
// Watches the command, result and register ports of the activation tracker,
// keeps its own per-bank activate counts and compares every refresh
// management beat against the oldest predicted one.
// ----------------------------------------------------------------------------
module act_tracker_checker #(
  parameter int unsigned BANK_COUNT = 64,
  parameter int unsigned NUM_RANKS  = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  rmat_pkg::cmd_item_t          item,
  input  logic                         result_valid,
  input  rmat_pkg::rfm_item_t          result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [rmat_pkg::PADDR_W-1:0] paddr,
  input  logic [rmat_pkg::PDATA_W-1:0] pwdata,
  output int                           errors,
  output int                           pending,
  output int                           rfm_count,
  output int                           act_count
);

  logic [rmat_pkg::CNT_W-1:0] act_cnt [BANK_COUNT];
  logic [rmat_pkg::CNT_W-1:0] threshold;
  logic                       per_bank;
  rmat_pkg::rfm_item_t        rfm_expected_q [$];

  function automatic string fmt_rfm(input rmat_pkg::rfm_item_t r);
    return $sformatf("all_bank=%0d rank=%0d bank=%0d",
                     r.all_bank, r.target_rank, r.target_bank);
  endfunction

  function void note_fail(input string msg);
    errors++;
    if (errors <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endfunction

  // one accepted command; an activate that reaches the threshold queues a beat
  task automatic count_activate(input rmat_pkg::cmd_item_t cmd);
    logic [rmat_pkg::CNT_W-1:0] n;
    rmat_pkg::rfm_item_t        rfm;
    if (!cmd.opens_bank || cmd.flat_bank >= BANK_COUNT || cmd.rank >= NUM_RANKS) return;
    act_count++;
    n = act_cnt[cmd.flat_bank];
    if (n != rmat_pkg::CNT_MAX) n++;
    act_cnt[cmd.flat_bank] = n;
    if (n < threshold) return;
    rfm.all_bank    = !per_bank;
    rfm.target_rank = cmd.rank;
    rfm.target_bank = cmd.flat_bank;
    rfm_expected_q.push_back(rfm);
    if (per_bank) begin
      act_cnt[cmd.flat_bank] = '0;
    end else begin
      foreach (act_cnt[i]) act_cnt[i] = '0;
    end
  endtask

  task automatic check_rfm(input rmat_pkg::rfm_item_t got);
    rmat_pkg::rfm_item_t exp;
    rfm_count++;
    if (rfm_expected_q.size() == 0) begin
      note_fail({"unexpected beat ", fmt_rfm(got)});
      return;
    end
    exp = rfm_expected_q.pop_front();
    if (exp.all_bank !== got.all_bank || exp.target_rank !== got.target_rank ||
        exp.target_bank !== got.target_bank)
      note_fail({"expected ", fmt_rfm(exp), ", got ", fmt_rfm(got)});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (act_cnt[i]) act_cnt[i] = '0;
      threshold = rmat_pkg::THRESHOLD_RESET;
      per_bank  = 1'b0;
      rfm_expected_q.delete();
      errors    = 0;
      rfm_count = 0;
      act_count = 0;
    end else begin
      // compare first: a beat seen now belongs to an earlier command
      if (result_valid) check_rfm(result);
      if (start && !busy) count_activate(item);
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == rmat_pkg::REG_ACT_THRESHOLD) threshold = pwdata[rmat_pkg::CNT_W-1:0];
        else per_bank = pwdata[0];
      end
    end
    pending = rfm_expected_q.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives issued commands and register writes into the activation tracker
// across several threshold and mode settings; the checker predicts and
// compares the refresh management beats.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned BANK_COUNT = 64;
  localparam int unsigned NUM_RANKS  = 4;

  logic                         clk     = 1'b0;
  logic                         rst     = 1'b1;
  logic                         start   = 1'b0;
  rmat_pkg::cmd_item_t          item    = '0;
  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [rmat_pkg::PADDR_W-1:0] paddr   = '0;
  logic [rmat_pkg::PDATA_W-1:0] pwdata  = '0;
  logic                         busy;
  logic                         result_valid;
  rmat_pkg::rfm_item_t          result;
  logic [rmat_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  int       errors, pending, rfm_count, act_count;
  int       sent = 0;
  logic [5:0] hot_bank [4];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  refresh_management_act_tracker #(
    .BANK_COUNT (BANK_COUNT),
    .NUM_RANKS  (NUM_RANKS)
  ) i_dut (
    .clk, .rst, .start, .busy, .item, .result_valid, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  act_tracker_checker #(
    .BANK_COUNT (BANK_COUNT),
    .NUM_RANKS  (NUM_RANKS)
  ) i_checker (
    .clk, .rst, .start, .busy, .item, .result_valid, .result,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors, .pending, .rfm_count, .act_count
  );

  function automatic rmat_pkg::cmd_item_t mk_cmd(input logic ob, input logic [1:0] r,
                                                 input logic [5:0] b);
    rmat_pkg::cmd_item_t c;
    c.opens_bank = ob;
    c.rank       = r;
    c.flat_bank  = b;
    return c;
  endfunction

  // mostly activates, most of them on a few hot banks so counts build up
  function automatic rmat_pkg::cmd_item_t pick_cmd(input int hot_n);
    rmat_pkg::cmd_item_t c;
    c = rmat_pkg::cmd_item_t'($urandom);
    if ($urandom_range(7) == 0) begin
      c.opens_bank = 1'b0;
    end else begin
      c.opens_bank = 1'b1;
      if ($urandom_range(99) < 80) c.flat_bank = hot_bank[$urandom_range(hot_n - 1)];
    end
    return c;
  endfunction

  task automatic pick_hot();
    foreach (hot_bank[i]) begin
      case ($urandom_range(3))
        0:       hot_bank[i] = 6'd0;
        1:       hot_bank[i] = 6'd63;
        default: hot_bank[i] = 6'($urandom);
      endcase
    end
  endtask

  // entered and left at a falling edge
  task automatic send_cmd(input rmat_pkg::cmd_item_t cmd);
    int idle_pct;
    idle_pct = (sent < 183) ? 20 : ((sent < 366) ? 48 : 0);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      item  <= rmat_pkg::cmd_item_t'($urandom);
      @(negedge clk);
    end
    start <= 1'b1;
    item  <= cmd;
    while (busy) @(negedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic run_random(input int n, input int hot_n);
    repeat (n) send_cmd(pick_cmd(hot_n));
  endtask

  // drain expected beats, then let a command with no beat finish
  task automatic wait_idle();
    int guard;
    guard = 0;
    start <= 1'b0;
    while ((pending != 0 || busy) && guard < 2000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  // leaves the bus idle after the access
  task automatic apb_write(input logic reg_sel, input logic [rmat_pkg::PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_cfg(input logic [rmat_pkg::CNT_W-1:0] thr, input logic mode);
    wait_idle();
    apb_write(rmat_pkg::REG_ACT_THRESHOLD, rmat_pkg::PDATA_W'(thr));
    apb_write(rmat_pkg::REG_PER_BANK_MODE, rmat_pkg::PDATA_W'(mode));
  endtask

  initial begin
    #2_000_000;
    $display("timeout: %0d commands sent, %0d beats pending", sent, pending);
    $display("** refresh_management_act_tracker: FAILED **");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: threshold 80, all-bank
    send_cmd(mk_cmd(1'b0, 2'd3, 6'd63));
    send_cmd(mk_cmd(1'b0, 2'd0, 6'd0));
    send_cmd(mk_cmd(1'b1, 2'd0, 6'd0));
    send_cmd(mk_cmd(1'b1, 2'd3, 6'd63));
    send_cmd(mk_cmd(1'b1, 2'd2, 6'd21));
    send_cmd(mk_cmd(1'b1, 2'd1, 6'd42));
    send_cmd(mk_cmd(1'b0, 2'd1, 6'd42));
    send_cmd(mk_cmd(1'b1, 2'd3, 6'd0));
    pick_hot();
    run_random(170, 1);

    // every activate fires, per bank
    set_cfg(16'd1, 1'b1);
    send_cmd(mk_cmd(1'b1, 2'd0, 6'd0));
    send_cmd(mk_cmd(1'b1, 2'd3, 6'd63));
    send_cmd(mk_cmd(1'b1, 2'd1, 6'd63));
    send_cmd(mk_cmd(1'b1, 2'd2, 6'd0));
    send_cmd(mk_cmd(1'b0, 2'd3, 6'd63));
    send_cmd(mk_cmd(1'b1, 2'd2, 6'd42));
    pick_hot();
    run_random(40, 4);

    // zero threshold: every activate fires even from a clear count
    set_cfg(16'd0, 1'b0);
    send_cmd(mk_cmd(1'b1, 2'd3, 6'd21));
    send_cmd(mk_cmd(1'b0, 2'd0, 6'd21));
    send_cmd(mk_cmd(1'b1, 2'd0, 6'd63));
    send_cmd(mk_cmd(1'b1, 2'd1, 6'd0));
    run_random(30, 4);

    // max threshold: counts build up, nothing fires
    set_cfg(16'hffff, 1'b1);
    pick_hot();
    run_random(120, 2);

    // threshold dropped under the built-up counts: next activate fires
    set_cfg(16'd2, 1'b1);
    send_cmd(mk_cmd(1'b1, 2'd2, hot_bank[0]));
    send_cmd(mk_cmd(1'b1, 2'd1, hot_bank[1]));
    pick_hot();
    run_random(60, 4);

    set_cfg(16'd6, 1'b0);
    pick_hot();
    run_random(60, 3);

    set_cfg(16'($urandom_range(2, 20)), 1'($urandom_range(1)));
    pick_hot();
    run_random(60, 4);

    wait_idle();
    repeat (8) @(negedge clk);

    $display("Sent %0d commands (%0d activates) across seven register settings,",
             sent, act_count);
    $display("checked %0d refresh management beats in both all-bank and per-bank mode.",
             rfm_count);
    if (pending != 0) $display("%0d expected beats never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("** refresh_management_act_tracker: PASSED **");
    end else begin
      $display("** refresh_management_act_tracker: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/rmat_pkg.sv
sv/rmat_cnt_mem.sv
sv/refresh_management_act_tracker.sv
tb/act_tracker_checker.sv
tb/testbench.sv
